// File: src/wishart_nearest_center_labeler_core_defines.svh
// Assertion macros for the nearest-center labeler core.
`ifndef WISHART_NEAREST_CENTER_LABELER_CORE_DEFINES_SVH
`define WISHART_NEAREST_CENTER_LABELER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WNCL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define WNCL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/wncl_pkg.sv
// Shared types and constants of the nearest-center labeler.
package wncl_pkg;
  localparam int MaxCenters   = 16;
  localparam int MaxPositions = 64;
  localparam int Entries      = 9;
  localparam int CW   = $clog2(MaxCenters);
  localparam int PW   = $clog2(MaxPositions);
  localparam int MatDepth = MaxCenters * MaxPositions * Entries;
  localparam int LogDepth = MaxCenters * MaxPositions;
  localparam int MAW  = $clog2(MatDepth);
  localparam int LAW  = $clog2(LogDepth);

  localparam logic [1:0] ActLoadEntry = 2'd0;
  localparam logic [1:0] ActLoadLog   = 2'd1;
  localparam logic [1:0] ActSample    = 2'd2;

  localparam logic CfgMode    = 1'b0;
  localparam logic CfgCenters = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic          rd;       // issue store read for center
    logic [CW-1:0] rd_ctr;
    logic          acc;      // accumulate read data into center
    logic [CW-1:0] acc_ctr;
    logic          cmp;      // compare center against best
    logic [CW-1:0] cmp_ctr;
    logic          clr;      // clear all accumulators
  } dp_cmd_t;
endpackage

// File: src/wncl_datapath.sv
// Datapath: stores, shared multiply-accumulate, minimum search.
module wncl_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  wncl_pkg::dp_cmd_t     cmd_i,
  input  logic                  mode_i,
  input  logic [1:0]            action_i,
  input  logic [3:0]            center_i,
  input  logic [5:0]            pos_i,
  input  logic [3:0]            entry_i,
  input  logic signed [31:0]    vre_i,
  input  logic signed [31:0]    vim_i,
  output logic [3:0]            label_o,
  output logic signed [63:0]    best_o
);
  import wncl_pkg::*;

  logic signed [31:0] re_mem [MatDepth];
  logic signed [31:0] im_mem [MatDepth];
  logic signed [31:0] lg_mem [LogDepth];
  logic signed [63:0] acc_q [MaxCenters];

  logic [1:0]  act_q;
  logic [3:0]  ctr_q, ent_q;
  logic [5:0]  pos_q;
  logic signed [31:0] vre_q, vim_q;
  logic        valid_q;

  // Latch beat at the accepting edge
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      act_q <= action_i; ctr_q <= center_i; pos_q <= pos_i;
      ent_q <= entry_i; vre_q <= vre_i; vim_q <= vim_i;
    end
  end
  assign valid_q = ({2'b0, pos_q} < 8'(MaxPositions)) && (ent_q < 4'(Entries));

  // Transposed entry index
  logic [3:0] tr;
  always_comb begin
    case (ent_q)
      4'd1: tr = 4'd3; 4'd2: tr = 4'd6; 4'd3: tr = 4'd1;
      4'd5: tr = 4'd7; 4'd6: tr = 4'd2; 4'd7: tr = 4'd5;
      default: tr = ent_q;
    endcase
  end

  logic [MAW-1:0] wa, ra;
  logic [LAW-1:0] lwa, lra;
  assign wa  = MAW'((32'(ctr_q) * MaxPositions + 32'(pos_q)) * Entries + 32'(ent_q));
  assign lwa = LAW'(32'(ctr_q) * MaxPositions + 32'(pos_q));
  assign ra  = MAW'((32'(cmd_i.rd_ctr) * MaxPositions + 32'(pos_q)) * Entries
               + 32'(mode_i ? 4'd0 : tr));
  assign lra = LAW'(32'(cmd_i.rd_ctr) * MaxPositions + 32'(pos_q));

  // Store writes and registered reads
  logic signed [31:0] rre_q, rim_q, rlg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd && act_q == ActLoadEntry && valid_q) begin
      re_mem[wa] <= vre_q; im_mem[wa] <= vim_q;
    end
    if (cmd_i.rd && act_q == ActLoadLog && {2'b0, pos_q} < 8'(MaxPositions))
      lg_mem[lwa] <= vre_q;
    if (cmd_i.rd) begin
      rre_q <= re_mem[ra]; rim_q <= im_mem[ra]; rlg_q <= lg_mem[lra];
    end
  end

  // Products, registered
  logic signed [63:0] p1_q, p2_q, lt_q, l1_q;
  logic               ph_q;
  logic [CW-1:0]      pc_q;
  logic signed [32:0] dif;
  assign dif = 33'(vre_q) - 33'(rre_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= 1'b0;
    else ph_q <= cmd_i.acc;
  end
  always_ff @(posedge clk_i) begin
    pc_q <= cmd_i.acc_ctr;
    p1_q <= rre_q * vre_q;
    p2_q <= rim_q * vim_q;
    lt_q <= 64'(rlg_q) <<< 16;
    l1_q <= 64'(dif[32] ? -dif : dif) <<< 16;
  end

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Accumulate: one center per cycle
  logic signed [63:0] a1, a2;
  always_comb begin
    a1 = acc_q[pc_q];
    a2 = a1;
    if (!mode_i) begin
      a1 = sat_add(a1, p1_q - p2_q);
      a2 = (ent_q == 4'd0) ? sat_add(a1, lt_q) : a1;
    end else if (ent_q == 4'd0) begin
      a2 = sat_add(a1, l1_q);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxCenters; k++) acc_q[k] <= '0;
    end else if (cmd_i.clr) begin
      for (int k = 0; k < MaxCenters; k++) acc_q[k] <= '0;
    end else if (ph_q && valid_q) begin
      acc_q[pc_q] <= a2;
    end
  end

  // Minimum search, lowest index wins ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      if (cmd_i.cmp_ctr == '0 || acc_q[cmd_i.cmp_ctr] < best_o) begin
        best_o  <= acc_q[cmd_i.cmp_ctr];
        label_o <= cmd_i.cmp_ctr;
      end
    end
  end
endmodule

// File: src/wncl_ctrl.sv
// Controller: sequences store access, accumulation and search.
module wncl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [1:0]        action_i,
  input  logic              last_i,
  input  logic [4:0]        n_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic              start_o,
  output wncl_pkg::dp_cmd_t cmd_o
);
  import wncl_pkg::*;

  typedef enum logic [2:0] {SIdle, SLoad, SRun, SDrain, SCmp, SOut} state_e;
  state_e  state_q;
  logic [CW:0] cnt_q;
  logic        last_q;
  logic [CW:0] nsat;
  dp_cmd_t     cmd_d;

  assign nsat = (n_i == 5'd0) ? (CW+1)'(1) :
                (n_i > 5'(MaxCenters)) ? (CW+1)'(MaxCenters) : (CW+1)'(n_i);
  assign in_ready_o = (state_q == SIdle) && !out_valid_o;
  // datapath latches the beat at the accepting edge
  assign start_o = in_fire_i;

  // Next command from state and counter
  always_comb begin
    cmd_d = '0;
    case (state_q)
      SLoad: cmd_d.rd = 1'b1;
      SRun: begin
        // read, then accumulate registered products, one center each cycle
        cmd_d.rd = 1'b1; cmd_d.rd_ctr = cnt_q[CW-1:0];
        if (cnt_q != '0) begin
          cmd_d.acc = 1'b1; cmd_d.acc_ctr = CW'(cnt_q - 1'b1);
        end
      end
      SDrain: begin
        cmd_d.acc = 1'b1; cmd_d.acc_ctr = CW'(MaxCenters - 1);
      end
      SCmp: begin
        // no compare before the pipelined accumulation has settled
        if (last_q && cnt_q == nsat + (CW+1)'(2)) begin
          cmd_d.clr = 1'b1;
        end else if (last_q && cnt_q >= (CW+1)'(2)) begin
          cmd_d.cmp = 1'b1; cmd_d.cmp_ctr = CW'(cnt_q - (CW+1)'(2));
        end
      end
      default: cmd_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; last_q <= 1'b0;
      out_valid_o <= 1'b0; cmd_o <= '0;
    end else begin
      cmd_o <= cmd_d;
      if (state_q == SOut) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        SIdle: if (in_fire_i) begin
          last_q <= last_i;
          cnt_q <= '0;
          state_q <= (action_i == ActSample) ? SRun : SLoad;
        end
        SLoad: state_q <= SIdle;
        SRun: begin
          if (cnt_q == (CW+1)'(MaxCenters - 1)) begin
            cnt_q <= '0; state_q <= SDrain;
          end else cnt_q <= cnt_q + 1'b1;
        end
        SDrain: begin
          state_q <= SCmp; cnt_q <= '0;
        end
        SCmp: begin
          if (!last_q) state_q <= SIdle;
          else if (cnt_q == nsat + (CW+1)'(2)) state_q <= SOut;
          else cnt_q <= cnt_q + 1'b1;
        end
        SOut: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: src/wishart_nearest_center_labeler_core.sv
// Top level of the nearest-center labeler core.
// Usage: config port writes distance_mode (index 0) and centers_in_use
// (index 1) while idle. Input beats on s_axis: tuser = action, tlast =
// last_entry, tdata = center, position, entry, value_re, value_im.
// A load beat passes through the load state before the next beat is taken.
// A sample beat visits all 16 centers with one shared multiply-accumulate;
// the next beat is taken once the run, drain and compare states are done.
// With tlast set the minimum search over the first centers_in_use centers
// (taken as 1..16) follows. The result (label, best distance) appears
// on m_axis and is held until m_axis_tready; no new beat is taken while
// a result waits, the next one is taken the cycle after it is accepted.
// Reset clears accumulators, control and config registers only; the
// coefficient stores are not cleared and must be loaded before use.
module wishart_nearest_center_labeler_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: center_index[3:0], patch_position[9:4], entry_index[13:10],
  // value_re[45:14], value_im[77:46], zero fill
  input  logic [79:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: label[3:0], best_distance[67:4], zero fill
  output logic [71:0]  m_axis_tdata
);
  import wncl_pkg::*;
  `include "wishart_nearest_center_labeler_core_defines.svh"

  logic       mode_q;
  logic [4:0] n_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; n_q <= 5'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgMode) mode_q <= cfg_wdata_i[0];
      else n_q <= cfg_wdata_i;
    end
  end

  dp_cmd_t cmd;
  logic    fire;
  logic    start;
  logic [3:0] label;
  logic signed [63:0] best;
  assign fire = s_axis_tvalid && s_axis_tready;

  wncl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .action_i(s_axis_tuser),
    .last_i(s_axis_tlast), .n_i(n_q), .out_ready_i(m_axis_tready),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid), .start_o(start),
    .cmd_o(cmd)
  );

  wncl_datapath u_dp (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(cmd), .mode_i(mode_q),
    .action_i(s_axis_tuser),
    .center_i(s_axis_tdata[3:0]), .pos_i(s_axis_tdata[9:4]),
    .entry_i(s_axis_tdata[13:10]), .vre_i(s_axis_tdata[45:14]),
    .vim_i(s_axis_tdata[77:46]), .label_o(label), .best_o(best)
  );

  assign m_axis_tdata = {4'd0, best, label};

  `WNCL_ASSERT_IMP(a_no_accept_busy, m_axis_tvalid, !s_axis_tready)
  `WNCL_ASSERT_NXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `WNCL_ASSERT_IMP(a_cmd_excl, cmd.clr, !cmd.acc)
endmodule

// File: tb/sv/tb_wishart_nearest_center_labeler_core.sv
// Testbench for the nearest-center labeler core: random and directed beats vs. a predictor.
module tb_wishart_nearest_center_labeler_core;
  import wncl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgMode;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic signed [63:0] best_dist;
    logic [3:0]         label;
  } label_t;

  wishart_nearest_center_labeler_core uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] inv_re [MatDepth];
  logic signed [31:0] inv_im [MatDepth];
  logic signed [31:0] log_term [LogDepth];
  logic signed [63:0] dist_acc [MaxCenters];
  logic               mode_l1;
  logic [4:0]         n_centers;
  label_t             labels_due [$];
  int                 errors = 0;
  int                 idle_pct_tx;
  int                 idle_pct_rx;
  bit                 hold_req = 1'b0;
  logic               hold_rx;
  int                 quiet = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // apply one beat to the predictor
  task automatic predict(input logic [1:0] act, input logic [3:0] ctr, input logic [5:0] pos,
                         input logic [3:0] ent, input logic signed [31:0] vre,
                         input logic signed [31:0] vim, input logic last);
    int base, tr, n, best;
    logic signed [63:0] p, bestd;
    label_t item;
    if (act == ActLoadEntry) begin
      if (ent < Entries) begin
        base = (ctr * MaxPositions + pos) * Entries + ent;
        inv_re[base] = vre; inv_im[base] = vim;
      end
    end else if (act == ActLoadLog) begin
      log_term[ctr * MaxPositions + pos] = vre;
    end else if (act == ActSample) begin
      if (ent < Entries) begin
        tr = (ent % 3) * 3 + ent / 3;
        for (int k = 0; k < MaxCenters; k++) begin
          base = (k * MaxPositions + pos) * Entries;
          if (!mode_l1) begin
            p = 64'(inv_re[base + tr]) * 64'(vre) - 64'(inv_im[base + tr]) * 64'(vim);
            dist_acc[k] = sat_add(dist_acc[k], p);
            if (ent == 0)
              dist_acc[k] = sat_add(dist_acc[k], 64'(log_term[k * MaxPositions + pos]) <<< 16);
          end else if (ent == 0) begin
            p = 64'(vre) - 64'(inv_re[base]);
            if (p < 0) p = -p;
            dist_acc[k] = sat_add(dist_acc[k], p <<< 16);
          end
        end
      end
      if (last) begin
        n = (n_centers == 0) ? 1 : (n_centers > MaxCenters ? MaxCenters : n_centers);
        best = 0; bestd = dist_acc[0];
        for (int k = 1; k < n; k++)
          if (dist_acc[k] < bestd) begin bestd = dist_acc[k]; best = k; end
        item.label = 4'(best);
        item.best_dist = bestd;
        labels_due = {labels_due, item};
        for (int k = 0; k < MaxCenters; k++) dist_acc[k] = '0;
      end
    end
  endtask

  // send one beat, wait for acceptance
  task automatic send_beat(input logic [1:0] act, input logic [3:0] ctr, input logic [5:0] pos,
                           input logic [3:0] ent, input logic [31:0] vre, input logic [31:0] vim,
                           input logic last);
    while ($urandom_range(99) < idle_pct_tx) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {2'b00, vim, vre, ent, pos, ctr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(act, ctr, pos, ent, vre, vim, last);
  endtask

  // stop offering, wait for results, then for the tail of a possible non-result beat
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (labels_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [4:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMode) mode_l1 = val[0]; else n_centers = val;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(8'hFF)) << 16;
      3: return -(32'($urandom_range(8'hFF)) << 16);
      default: return $urandom;
    endcase
  endfunction

  // fill every center's data for positions 0..npos-1
  task automatic load_tables(input int npos);
    for (int c = 0; c < MaxCenters; c++)
      for (int p = 0; p < npos; p++) begin
        send_beat(ActLoadLog, 4'(c), 6'(p), 4'($urandom), rand_value(), $urandom,
                  1'($urandom));
        for (int e = 0; e < Entries; e++)
          send_beat(ActLoadEntry, 4'(c), 6'(p), 4'(e), rand_value(), rand_value(),
                    1'($urandom));
      end
  endtask

  // one patch of positions 0..npos-1, all entries
  task automatic send_patch(input int npos);
    for (int p = 0; p < npos; p++)
      for (int e = 0; e < Entries; e++)
        send_beat(ActSample, 4'($urandom), 6'(p), 4'(e), rand_value(), rand_value(),
                  (p == npos - 1) && (e == Entries - 1));
  endtask

  task automatic test_directed();
    load_tables(2);
    // extremes, ignored action, out-of-range entries
    send_beat(ActUnused, 4'hF, 6'h3F, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(ActLoadEntry, 4'hF, 6'd1, 4'd12, 32'h1234, 32'h5678, 1'b0);
    send_beat(ActSample, 4'hF, 6'd0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_beat(ActSample, 4'h0, 6'd1, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_beat(ActSample, 4'h0, 6'd0, 4'd9, 32'h0, 32'h0, 1'b1);
    // saturation: extreme sample values many times in a row
    for (int i = 0; i < 8; i++)
      send_beat(ActSample, 4'h0, 6'd0, 4'd4, 32'h8000_0000, 32'h7FFF_FFFF, i == 7);
    // ties: equal tables give label zero
    for (int c = 0; c < MaxCenters; c++) begin
      send_beat(ActLoadLog, 4'(c), 6'd2, 4'd0, 32'h10000, 32'h0, 1'b0);
      for (int e = 0; e < Entries; e++)
        send_beat(ActLoadEntry, 4'(c), 6'd2, 4'(e), 32'h10000, 32'h0, 1'b0);
    end
    send_beat(ActSample, 4'h0, 6'd2, 4'd0, 32'h10000, 32'h0, 1'b1);
    drain();
  endtask

  task automatic test_random(input int beats);
    int sent, npos, k;
    sent = 0;
    while (sent < beats) begin
      npos = 2 + $urandom_range(1);
      k = $urandom_range(9);
      if (k == 0) begin
        send_beat(ActUnused, 4'($urandom), 6'($urandom), 4'($urandom), $urandom, $urandom,
                  1'($urandom));
      end else if (k == 1) begin
        // broken patch: stray samples, some out of range entry
        send_beat(ActSample, 4'($urandom), 6'($urandom_range(npos - 1)), 4'($urandom_range(15)),
                  rand_value(), rand_value(), $urandom_range(3) == 0);
        sent++;
      end else if (k == 2) begin
        send_beat(ActLoadEntry, 4'($urandom), 6'($urandom_range(2)), 4'($urandom_range(8)),
                  rand_value(), rand_value(), 1'b0);
        sent++;
      end else begin
        send_patch(npos);
        sent += npos * Entries;
      end
    end
    drain();
  endtask

  // receiver holds off while sender keeps going
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_patch(1);
    drain();
  endtask

  // long receiver hold-off, counted in cycles here
  initial begin
    hold_rx = 1'b0;
    wait (hold_req);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // result checker and receiver idling
  always @(posedge clk_i) begin
    label_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[67:0];
      if (labels_due.size() == 0) begin
        report("unexpected result", 64'(got.label), 64'h0);
      end else begin
        want = labels_due.pop_front();
        if (got.label !== want.label) report("label", 64'(got.label), 64'(want.label));
        if (got.best_dist !== want.best_dist)
          report("best_distance", got.best_dist, want.best_dist);
      end
    end
    if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct_rx);
    end
  end

  // watchdog on cycles without any accepted beat or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    idle_pct_tx = 28; idle_pct_rx = 28;
    mode_l1 = 1'b0; n_centers = 5'd16;
    for (int k = 0; k < MaxCenters; k++) dist_acc[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_cfg(CfgCenters, 5'd1);
    test_random(200);
    write_cfg(CfgMode, 5'd1);
    write_cfg(CfgCenters, 5'd7);
    test_random(200);
    // no idling stretch
    idle_pct_tx = 0; idle_pct_rx = 0;
    write_cfg(CfgCenters, 5'd16);
    test_random(200);
    idle_pct_tx = 28; idle_pct_rx = 28;
    write_cfg(CfgMode, 5'd0);
    test_random(250);
    test_backpressure();
    write_cfg(CfgCenters, 5'd2);
    test_random(200);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
